>>> hw/rtl/rti_pkg.sv
`timescale 1ns / 1ps

package rti_pkg;

  // Width of the sums a, u, v and t before division.
  localparam int PW = 103;
  // Width of the divisor |a|.
  localparam int DW = 101;
  // Width of the dividend t * 2^16.
  localparam int NW = 120;
  // Quotient bits kept; larger quotients are clamped.
  localparam int QB = 49;
  // Width of the divisor compare in the divider.
  localparam int CW = DW + QB;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_EPSILON  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } ctl_t;

endpackage

>>> hw/rtl/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// The pipeline has 64 register stages from an accepted request to its valid result.
// Throughput: one triangle per cycle; the pipeline advances whenever the output register
// is empty or being taken, and the 49-stage quotient pipeline sets the depth.
// Reset clears all valid bits and loads the ray registers with origin 0, direction +z
// and epsilon 1.

module ray_triangle_intersect (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // distance, hit_x, hit_y, hit_z, zero pad
  output logic [0:0]   m_tuser,   // hit
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int PW = rti_pkg::PW;
  localparam int DW = rti_pkg::DW;
  localparam int NW = rti_pkg::NW;
  localparam int QB = rti_pkg::QB;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic [15:0]        eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      org <= '{default: '0};
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= 32'sd65536;
      eps <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_ORIGIN_X: org[0] <= cfg_data;
        rti_pkg::REG_ORIGIN_Y: org[1] <= cfg_data;
        rti_pkg::REG_ORIGIN_Z: org[2] <= cfg_data;
        rti_pkg::REG_DIR_X:    dir[0] <= cfg_data;
        rti_pkg::REG_DIR_Y:    dir[1] <= cfg_data;
        rti_pkg::REG_DIR_Z:    dir[2] <= cfg_data;
        rti_pkg::REG_EPSILON:  eps <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce = m_tready || !m_tvalid;
  assign s_tready = ce;

  logic [10:1] vld;
  logic [3:1]  vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[9:1], s_tvalid};
    end
  end

  logic signed [31:0] vin [9];
  for (genvar n = 0; n < 9; n++) begin : g_unpack
    assign vin[n] = s_tdata[n*32 +: 32];
  end

  logic signed [32:0]  e1_1 [3], e2_1 [3], s_1 [3];
  logic signed [32:0]  e1_2 [3], e2_2 [3], s_2 [3];
  logic signed [32:0]  e1_3 [3], e2_3 [3], s_3 [3];
  logic signed [64:0]  hpa [3], hpb [3];
  logic signed [65:0]  qpa [3], qpb [3];
  logic signed [65:0]  h_3 [3];
  logic signed [66:0]  q_3 [3];
  logic signed [65:0]  lo_a [3], lo_u [3], lo_v [3], lo_t [3];
  logic signed [67:0]  hi_a [3], hi_u [3], hi_v [3], hi_t [3];
  logic signed [PW-1:0] m_a [3], m_u [3], m_v [3], m_t [3];

  for (genvar k = 0; k < 3; k++) begin : g_vec
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    always_ff @(posedge clk) begin
      if (ce) begin
        e1_1[k] <= $signed({vin[3+k][31], vin[3+k]}) - $signed({vin[k][31], vin[k]});
        e2_1[k] <= $signed({vin[6+k][31], vin[6+k]}) - $signed({vin[k][31], vin[k]});
        s_1[k]  <= $signed({org[k][31], org[k]}) - $signed({vin[k][31], vin[k]});

        hpa[k] <= dir[K1] * e2_1[K2];
        hpb[k] <= dir[K2] * e2_1[K1];
        qpa[k] <= s_1[K1] * e1_1[K2];
        qpb[k] <= s_1[K2] * e1_1[K1];
        e1_2[k] <= e1_1[k];
        e2_2[k] <= e2_1[k];
        s_2[k]  <= s_1[k];

        h_3[k]  <= 66'(hpa[k]) - 66'(hpb[k]);
        q_3[k]  <= 67'(qpa[k]) - 67'(qpb[k]);
        e1_3[k] <= e1_2[k];
        e2_3[k] <= e2_2[k];
        s_3[k]  <= s_2[k];

        lo_a[k] <= e1_3[k] * $signed({1'b0, h_3[k][31:0]});
        hi_a[k] <= e1_3[k] * $signed(h_3[k][65:32]);
        lo_u[k] <= s_3[k] * $signed({1'b0, h_3[k][31:0]});
        hi_u[k] <= s_3[k] * $signed(h_3[k][65:32]);
        lo_v[k] <= dir[k] * $signed({1'b0, q_3[k][31:0]});
        hi_v[k] <= dir[k] * $signed(q_3[k][66:32]);
        lo_t[k] <= e2_3[k] * $signed({1'b0, q_3[k][31:0]});
        hi_t[k] <= e2_3[k] * $signed(q_3[k][66:32]);

        m_a[k] <= (PW'(hi_a[k]) <<< 32) + PW'(lo_a[k]);
        m_u[k] <= (PW'(hi_u[k]) <<< 32) + PW'(lo_u[k]);
        m_v[k] <= (PW'(hi_v[k]) <<< 32) + PW'(lo_v[k]);
        m_t[k] <= (PW'(hi_t[k]) <<< 32) + PW'(lo_t[k]);
      end
    end
  end

  logic signed [PW-1:0] sa6, su6, sv6, st6;
  logic signed [PW-1:0] a7, u7, v7, t7;
  logic [PW:0]          ax7;
  logic [41:0]          pe8 [4];
  logic                 pass8, pass9;
  logic [DW-1:0]        a8, a9;
  logic signed [PW-1:0] t8, t9;
  logic [NW-1:0]        ea9;
  logic [NW-1:0]        num10;
  logic [DW-1:0]        den10;
  logic                 hit10;

  assign ax7 = {1'b0, a7};

  always_ff @(posedge clk) begin
    if (ce) begin
      sa6 <= m_a[0] + m_a[1] + m_a[2];
      su6 <= m_u[0] + m_u[1] + m_u[2];
      sv6 <= m_v[0] + m_v[1] + m_v[2];
      st6 <= m_t[0] + m_t[1] + m_t[2];

      a7 <= sa6[PW-1] ? -sa6 : sa6;
      u7 <= sa6[PW-1] ? -su6 : su6;
      v7 <= sa6[PW-1] ? -sv6 : sv6;
      t7 <= sa6[PW-1] ? -st6 : st6;

      pass8 <= !((a7 == '0) || (a7 < $signed(PW'({eps, 32'd0})))
                 || u7[PW-1] || (a7 < u7)
                 || v7[PW-1] || (a7 < (u7 + v7)));
      for (int j = 0; j < 4; j++) begin
        pe8[j] <= eps * ax7[j*26 +: 26];
      end
      a8 <= a7[DW-1:0];
      t8 <= t7;

      ea9 <= NW'(pe8[0]) + (NW'(pe8[1]) << 26) + (NW'(pe8[2]) << 52) + (NW'(pe8[3]) << 78);
      pass9 <= pass8;
      a9 <= a8;
      t9 <= t8;

      hit10 <= pass9 && !t9[PW-1] && (ea9 < NW'({t9, 16'd0}));
      num10 <= NW'({t9, 16'd0});
      den10 <= a9;
    end
  end

  rti_pkg::ctl_t   dctl;
  logic [QB-1:0]   tc;
  logic            big;

  rti_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_ctl  ('{vld: vld[10], hit: hit10}),
    .num     (num10),
    .den     (den10),
    .out_ctl (dctl),
    .tc      (tc),
    .big     (big)
  );

  logic signed [64:0] plo [3];
  logic signed [49:0] phi [3];
  logic signed [81:0] full12 [3];
  logic signed [66:0] sum13 [3];
  logic [31:0]        sat [3];
  logic [30:0]        dist11, dist12, dist13;
  logic               hit11, hit12, hit13;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      vp <= {vp[2:1], dctl.vld};
      m_tvalid <= vp[3];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign sat[k] = (!sum13[k][66] && (|sum13[k][65:31])) ? 32'h7FFF_FFFF :
                    (sum13[k][66] && !(&sum13[k][65:31])) ? 32'h8000_0000 :
                    sum13[k][31:0];

    always_ff @(posedge clk) begin
      if (ce) begin
        plo[k]    <= dir[k] * $signed({1'b0, tc[31:0]});
        phi[k]    <= dir[k] * $signed({1'b0, tc[QB-1:32]});
        full12[k] <= (82'(phi[k]) <<< 32) + 82'(plo[k]);
        sum13[k]  <= 67'(full12[k] >>> 16) + 67'(org[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit11  <= dctl.hit;
      dist11 <= big ? 31'h7FFF_FFFF : tc[30:0];
      hit12  <= hit11;
      dist12 <= dist11;
      hit13  <= hit12;
      dist13 <= dist12;
      m_tuser <= hit13;
      m_tdata <= hit13 ? {1'b0, sat[2], sat[1], sat[0], dist13} : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("miss result carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> ($stable(vld) && $stable(vp) && $stable(dctl.vld)))
    else $error("pipeline valid bits moved during a stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

>>> hw/rtl/rti_div.sv
`timescale 1ns / 1ps

module rti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  rti_pkg::ctl_t              in_ctl,
  input  logic [rti_pkg::NW-1:0]     num,
  input  logic [rti_pkg::DW-1:0]     den,
  output rti_pkg::ctl_t              out_ctl,
  output logic [rti_pkg::QB-1:0]     tc,
  output logic                       big
);

  localparam int NW = rti_pkg::NW;
  localparam int DW = rti_pkg::DW;
  localparam int QB = rti_pkg::QB;
  localparam int CW = rti_pkg::CW;

  logic [NW-1:0]   rem [0:QB];
  logic [DW-1:0]   dvs [0:QB];
  logic [QB-1:0]   quo [0:QB];
  logic            ovf [0:QB];
  rti_pkg::ctl_t   ctl [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (ce) begin
      ctl[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= num;
      dvs[0] <= den;
      quo[0] <= '0;
      ovf[0] <= CW'(num) >= (CW'(den) << QB);
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int BI = QB - j;
    logic [CW-1:0] shd;
    logic          take;

    assign shd  = CW'(dvs[j-1]) << BI;
    assign take = !ovf[j-1] && (CW'(rem[j-1]) >= shd);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j] <= '0;
      end else if (ce) begin
        ctl[j] <= ctl[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[j] <= take ? (rem[j-1] - shd[NW-1:0]) : rem[j-1];
        dvs[j] <= dvs[j-1];
        ovf[j] <= ovf[j-1];
        quo[j] <= quo[j-1] | (QB'(take) << BI);
      end
    end
  end

  assign out_ctl = ctl[QB];
  assign big     = ovf[QB] || (|quo[QB][QB-1:31]);
  assign tc      = (ovf[QB] || quo[QB][QB-1]) ? (QB'(1) << (QB - 1)) : quo[QB];

endmodule
